@@ hdl/dhlg_pkg.sv @@
// Shared types, constants and arithmetic helpers for the DH link frame generator.
package dhlg_pkg;

  // Internal CORDIC datapath width: Q2.30 plus guard bits
  localparam int unsigned CW = 34;
  localparam int unsigned ATAN_LEN = 40;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [31:0]   word_t;
  typedef logic signed [63:0]   prod_t;

  localparam cval_t GAIN_Q30  = cval_t'(652032874);
  localparam word_t ONE_Q30   = 32'sd1073741824;
  localparam word_t NEG_ONE_Q30 = -32'sd1073741824;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TBL [0:ATAN_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
    32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Rotation step for a given iteration; zero past the end of the table
  function automatic cval_t atan_step(input int unsigned idx);
    cval_t res;
    res = '0;
    if (idx < ATAN_LEN) begin
      res = cval_t'({2'b00, ATAN_TBL[idx[5:0]]});
    end
    return res;
  endfunction

  // Clamp a CORDIC value to [-1.0, 1.0] in Q2.30
  function automatic word_t clamp_q30(input cval_t v);
    word_t res;
    if (v > cval_t'(ONE_Q30)) begin
      res = ONE_Q30;
    end else if (v < cval_t'(NEG_ONE_Q30)) begin
      res = NEG_ONE_Q30;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Shift right by 30 with round half up
  function automatic logic signed [34:0] rnd30(input logic signed [64:0] p);
    logic signed [64:0] t;
    t = p + 65'sd536870912;
    return t[64:30];
  endfunction

  // Saturate a rounded value to the signed 32-bit range
  function automatic word_t sat_w32(input logic signed [34:0] v);
    word_t res;
    if (v > 35'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Saturate a rounded value to [-1.0, 1.0] in Q2.30
  function automatic word_t sat_q30(input logic signed [34:0] v);
    word_t res;
    if (v > 35'(ONE_Q30)) begin
      res = ONE_Q30;
    end else if (v < 35'(NEG_ONE_Q30)) begin
      res = NEG_ONE_Q30;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/dhlg_cordic_lane.sv @@
// One pipelined rotation-mode CORDIC lane: binary angle in, clamped sine and cosine out.
module dhlg_cordic_lane import dhlg_pkg::*; #(
  parameter int unsigned STEPS = 30
) (
  input  logic              clk,
  input  logic [STEPS+1:0]  en,
  input  logic [31:0]       angle,
  output word_t             sin_q,
  output word_t             cos_q
);

  cval_t x_r [0:STEPS];
  cval_t y_r [0:STEPS];
  cval_t z_r [0:STEPS];
  logic  flip_r [0:STEPS];
  word_t sin_r, cos_r;

  logic  flip_nxt;
  cval_t z0_nxt;

  // Fold quadrants 1 and 2 by a half turn; undo by negation at the end
  always_comb begin
    flip_nxt = angle[31] ^ angle[30];
    z0_nxt   = cval_t'($signed({angle[31] ^ flip_nxt, angle[30:0]}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= z0_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    cval_t x_nxt, y_nxt, z_nxt;
    cval_t dx, dy;
    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (!z_r[i][CW-1]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - atan_step(i);
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + atan_step(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  // Quadrant fix-up and clamp
  cval_t xf_nxt, yf_nxt;
  always_comb begin
    xf_nxt = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
    yf_nxt = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  end

  always_ff @(posedge clk) begin
    if (en[STEPS+1]) begin
      cos_r <= clamp_q30(xf_nxt);
      sin_r <= clamp_q30(yf_nxt);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

@@ hdl/dhlg_merge.sv @@
// Merge stage: forms the frame's products, then rounds and saturates into the output register.
module dhlg_merge import dhlg_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  word_t      sin_al,
  input  word_t      cos_al,
  input  word_t      sin_th,
  input  word_t      cos_th,
  input  word_t      len,
  input  word_t      off,
  output word_t      pos_x,
  output word_t      pos_y,
  output word_t      pos_z,
  output word_t      r00,
  output word_t      r01,
  output word_t      r10,
  output word_t      r11,
  output word_t      r12,
  output word_t      r20,
  output word_t      r21,
  output word_t      r22
);

  prod_t p_dsa_r, p_dca_r, p_cast_r, p_cact_r, p_sast_r, p_sact_r;
  word_t sa_r, ca_r, st_r, ct_r, len_r;

  // Product stage: one multiplier per product
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_dsa_r  <= prod_t'(off) * prod_t'(sin_al);
      p_dca_r  <= prod_t'(off) * prod_t'(cos_al);
      p_cast_r <= prod_t'(cos_al) * prod_t'(sin_th);
      p_cact_r <= prod_t'(cos_al) * prod_t'(cos_th);
      p_sast_r <= prod_t'(sin_al) * prod_t'(sin_th);
      p_sact_r <= prod_t'(sin_al) * prod_t'(cos_th);
      sa_r     <= sin_al;
      ca_r     <= cos_al;
      st_r     <= sin_th;
      ct_r     <= cos_th;
      len_r    <= len;
    end
  end

  word_t pos_x_r, pos_y_r, pos_z_r;
  word_t r00_r, r01_r, r10_r, r11_r, r12_r, r20_r, r21_r, r22_r;

  // Round, saturate and register the result
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos_x_r <= len_r;
      pos_y_r <= sat_w32(rnd30(-(65'(p_dsa_r))));
      pos_z_r <= sat_w32(rnd30(65'(p_dca_r)));
      r00_r   <= ct_r;
      r01_r   <= -st_r;
      r10_r   <= sat_q30(rnd30(65'(p_cast_r)));
      r11_r   <= sat_q30(rnd30(65'(p_cact_r)));
      r12_r   <= -sa_r;
      r20_r   <= sat_q30(rnd30(65'(p_sast_r)));
      r21_r   <= sat_q30(rnd30(65'(p_sact_r)));
      r22_r   <= ca_r;
    end
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;
  assign pos_z = pos_z_r;
  assign r00   = r00_r;
  assign r01   = r01_r;
  assign r10   = r10_r;
  assign r11   = r11_r;
  assign r12   = r12_r;
  assign r20   = r20_r;
  assign r21   = r21_r;
  assign r22   = r22_r;

endmodule

@@ hdl/dh_link_frame_generator.sv @@
// Top level of the DH link frame generator: two CORDIC lanes, merge stage, pipeline control.
//
// Usage:
//   Input channel in_valid/in_ready carries one DH parameter set per transfer
//   (link length, twist, offset, joint angle). The result channel
//   out_valid/out_ready carries the frame: origin and eight rotation entries.
//   Twist and joint angle run through two identical CORDIC lanes side by side;
//   the merge stage multiplies, rounds and saturates.
//   The item passes CORDIC_STEPS + 4 register stages (prep, loaded at the
//   transfer edge, one stage per CORDIC iteration, fix-up, product, output).
//   Throughput: one item per cycle while out_ready stays high, set by the fully
//   unrolled CORDIC pipeline and one multiplier per product.
//   Each stage has its own valid bit and advances whenever it is empty or its
//   successor advances, so bubbles collapse and input is taken while a result
//   waits in the output register. When the receiver stalls, the pipeline
//   fills up and in_ready drops only once every stage holds an item.
//   Reset (rst_n, synchronous, active low) clears all valid bits; the
//   datapath registers are not reset.
module dh_link_frame_generator import dhlg_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_link_length,
  input  logic [31:0] in_twist_angle,
  input  logic signed [31:0] in_link_offset,
  input  logic [31:0] in_joint_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_rot_row0_col0,
  output logic signed [31:0] out_rot_row0_col1,
  output logic signed [31:0] out_rot_row1_col0,
  output logic signed [31:0] out_rot_row1_col1,
  output logic signed [31:0] out_rot_row1_col2,
  output logic signed [31:0] out_rot_row2_col0,
  output logic signed [31:0] out_rot_row2_col1,
  output logic signed [31:0] out_rot_row2_col2
);

  localparam int unsigned LANE_ST = CORDIC_STEPS + 2;
  localparam int unsigned NST     = CORDIC_STEPS + 4;

  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST-1:0] en;

  // Stage k may load when any stage from k to the end is empty or the output drains
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ready || !(&vld_r[NST-1:k]);
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NST-1];

  // Length and offset ride alongside the CORDIC lanes
  word_t len_r [0:LANE_ST-1];
  word_t off_r [0:LANE_ST-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      len_r[0] <= in_link_length;
      off_r[0] <= in_link_offset;
    end
  end

  for (genvar k = 1; k < LANE_ST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        len_r[k] <= len_r[k-1];
        off_r[k] <= off_r[k-1];
      end
    end
  end

  word_t sin_al, cos_al, sin_th, cos_th;

  dhlg_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane_twist (
    .clk   (clk),
    .en    (en[LANE_ST-1:0]),
    .angle (in_twist_angle),
    .sin_q (sin_al),
    .cos_q (cos_al)
  );

  dhlg_cordic_lane #(.STEPS(CORDIC_STEPS)) u_lane_joint (
    .clk   (clk),
    .en    (en[LANE_ST-1:0]),
    .angle (in_joint_angle),
    .sin_q (sin_th),
    .cos_q (cos_th)
  );

  dhlg_merge u_merge (
    .clk    (clk),
    .en     (en[NST-1:LANE_ST]),
    .sin_al (sin_al),
    .cos_al (cos_al),
    .sin_th (sin_th),
    .cos_th (cos_th),
    .len    (len_r[LANE_ST-1]),
    .off    (off_r[LANE_ST-1]),
    .pos_x  (out_pos_x),
    .pos_y  (out_pos_y),
    .pos_z  (out_pos_z),
    .r00    (out_rot_row0_col0),
    .r01    (out_rot_row0_col1),
    .r10    (out_rot_row1_col0),
    .r11    (out_rot_row1_col1),
    .r12    (out_rot_row1_col2),
    .r20    (out_rot_row2_col0),
    .r21    (out_rot_row2_col1),
    .r22    (out_rot_row2_col2)
  );

  // A draining output always frees room at the input
  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready) else $error("in_ready low while output drains");

  // An empty output register means the pipeline cannot be full
  a_ready_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("in_ready low with empty output");

  // Every input transfer lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("accepted item lost at entry");

  // A held result must stay valid, with row1_col1 and pos_y unchanged, while stalled
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rot_row1_col1) && $stable(out_pos_y))
    else $error("stalled result changed");

  // Matrix entry row2_col1 stays within [-1.0, 1.0]
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_row2_col1 <= ONE_Q30) && (out_rot_row2_col1 >= NEG_ONE_Q30))
    else $error("rotation entry out of range");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the DH link frame generator: random traffic, predictor, scoreboard.
`timescale 1ns / 1ps

module tb;

  localparam int STEPS      = 30;
  localparam int LATENCY    = STEPS + 4;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 450;

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint W32_MAX  = 64'sd2147483647;
  localparam longint W32_MIN  = -64'sd2147483648;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ATAN_TURNS [0:39] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [31:0] length;
    logic [31:0]        twist;
    logic signed [31:0] offset;
    logic [31:0]        joint;
  } dh_params_t;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [31:0] r00, r01, r10, r11, r12, r20, r21, r22;
  } frame_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [31:0] in_link_length = '0;
  logic [31:0] in_twist_angle = '0;
  logic signed [31:0] in_link_offset = '0;
  logic [31:0] in_joint_angle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_rot_row0_col0, out_rot_row0_col1;
  logic signed [31:0] out_rot_row1_col0, out_rot_row1_col1, out_rot_row1_col2;
  logic signed [31:0] out_rot_row2_col0, out_rot_row2_col1, out_rot_row2_col2;

  dh_params_t link_queue [$];
  frame_t     frames_due [$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         gap_left = 0;
  int         burst_left = 1;
  int         stall_left = 0;
  int         stall_phase = 0;
  logic [15:0] stall_mask = '1;

  dh_link_frame_generator #(.CORDIC_STEPS(STEPS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Q2.30 product back to Q.30, round half up
  function automatic longint round_q30(input longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Rotation-mode CORDIC with half-turn fold for the middle quadrants
  function automatic void sin_cos_q30(input logic [31:0] ang, output longint s,
                                      output longint c);
    logic [31:0]        folded;
    logic signed [31:0] start;
    logic               flip;
    longint             x, y, z, dx, dy, step;
    flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    folded = flip ? ang - 32'h8000_0000 : ang;
    start  = folded;
    x = GAIN_Q30;
    y = 0;
    z = start;
    for (int i = 0; i < STEPS; i++) begin
      step = (i < 40) ? ATAN_TURNS[i] : 0;
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= step;
      end else begin
        x += dx; y -= dy; z += step;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, -ONE_Q30, ONE_Q30);
    s = clip(y, -ONE_Q30, ONE_Q30);
  endfunction

  function automatic frame_t dh_frame_of(input dh_params_t p);
    frame_t f;
    longint d, sa, ca, st, ct;
    d = p.offset;
    sin_cos_q30(p.twist, sa, ca);
    sin_cos_q30(p.joint, st, ct);
    f.px  = p.length;
    f.py  = 32'(clip(round_q30(-(d * sa)), W32_MIN, W32_MAX));
    f.pz  = 32'(clip(round_q30(d * ca), W32_MIN, W32_MAX));
    f.r00 = 32'(ct);
    f.r01 = 32'(-st);
    f.r10 = 32'(clip(round_q30(ca * st), -ONE_Q30, ONE_Q30));
    f.r11 = 32'(clip(round_q30(ca * ct), -ONE_Q30, ONE_Q30));
    f.r12 = 32'(-sa);
    f.r20 = 32'(clip(round_q30(sa * st), -ONE_Q30, ONE_Q30));
    f.r21 = 32'(clip(round_q30(sa * ct), -ONE_Q30, ONE_Q30));
    f.r22 = 32'(ca);
    return f;
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic logic [31:0] pick_angle();
    logic [31:0] base;
    case ($urandom_range(0, 5))
      0: begin
        // near a quadrant boundary, where the fold switches
        base = {2'($urandom_range(0, 3)), 30'd0};
        return base + $urandom_range(0, 16) - 32'd8;
      end
      1: begin
        base = {3'($urandom_range(0, 7)), 29'd0};
        return base + $urandom_range(0, 64) - 32'd32;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_length();
    logic signed [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return r >>> $urandom_range(8, 28);
      default: return r;
    endcase
  endfunction

  task automatic add_link(input logic [31:0] a, al, d, th);
    dh_params_t p;
    p.length = a;
    p.twist  = al;
    p.offset = d;
    p.joint  = th;
    link_queue.push_back(p);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin : drive
    dh_params_t nxt;
    dh_params_t sent;
    int r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sent.length = in_link_length;
        sent.twist  = in_twist_angle;
        sent.offset = in_link_offset;
        sent.joint  = in_joint_angle;
        frames_due.push_back(dh_frame_of(sent));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (link_queue.size() > 0) begin
          nxt = link_queue.pop_front();
          in_link_length <= nxt.length;
          in_twist_angle <= nxt.twist;
          in_link_offset <= nxt.offset;
          in_joint_angle <= nxt.joint;
          in_valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 80);
            r = $urandom_range(0, 9);
            if (r < 4) begin
              gap_left <= 0;
            end else if (r < 8) begin
              gap_left <= $urandom_range(1, 6);
            end else begin
              gap_left <= $urandom_range(7, 60);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver stall pattern ----------------

  always @(posedge clk) begin : stall_gen
    logic [15:0] mask;
    mask = stall_mask;
    if (stall_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1: mask = '1;
        2: mask = 16'($urandom) & 16'($urandom);
        default: mask = 16'($urandom);
      endcase
      stall_mask <= mask;
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_ready   <= mask[stall_phase];
    stall_phase <= (stall_phase + 1) % 16;
  end

  // ---------------- monitor / scoreboard ----------------

  task automatic check_word(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    frame_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        $error("result transfer with no frame pending");
        errors++;
      end else begin
        want = frames_due.pop_front();
        check_word("pos_x", want.px, out_pos_x);
        check_word("pos_y", want.py, out_pos_y);
        check_word("pos_z", want.pz, out_pos_z);
        check_word("rot_row0_col0", want.r00, out_rot_row0_col0);
        check_word("rot_row0_col1", want.r01, out_rot_row0_col1);
        check_word("rot_row1_col0", want.r10, out_rot_row1_col0);
        check_word("rot_row1_col1", want.r11, out_rot_row1_col1);
        check_word("rot_row1_col2", want.r12, out_rot_row1_col2);
        check_word("rot_row2_col0", want.r20, out_rot_row2_col0);
        check_word("rot_row2_col1", want.r21, out_rot_row2_col1);
        check_word("rot_row2_col2", want.r22, out_rot_row2_col2);
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------- sequence ----------------

  initial begin
    // field extremes, all four quadrants and the fold boundaries
    add_link(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_link(32'h7fff_ffff, 32'h4000_0000, 32'h7fff_ffff, 32'h4000_0000);
    add_link(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_link(32'h0001_0000, 32'hc000_0000, 32'h0001_0000, 32'hc000_0000);
    add_link(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_link(32'h1234_5678, 32'h3fff_ffff, 32'h0002_0000, 32'h3fff_ffff);
    add_link(32'hedcb_a988, 32'h7fff_ffff, 32'hfffe_0000, 32'h7fff_ffff);
    add_link(32'h0000_0001, 32'hbfff_ffff, 32'h0000_0001, 32'hbfff_ffff);
    add_link(32'h4000_0000, 32'h2000_0000, 32'h4000_0000, 32'h6000_0000);
    add_link(32'hc000_0000, 32'ha000_0000, 32'hc000_0000, 32'he000_0000);
    // offset at either end of its range with sine or cosine at full scale: position at or past the 32-bit limits
    add_link(32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'h0000_0000);
    add_link(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    add_link(32'h0000_0000, 32'hc000_0000, 32'h7fff_ffff, 32'h0000_0000);
    add_link(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    // just across the fold on either side of a half turn
    add_link(32'h0000_0100, 32'h4000_0001, 32'h0100_0000, 32'h8000_0001);
    add_link(32'hffff_ff00, 32'hc000_0001, 32'hff00_0000, 32'h7fff_fffe);
    add_link(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
    add_link(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa);
    add_link(32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001);
    add_link(32'h0000_0000, 32'hffff_fff0, 32'h7fff_ffff, 32'h4000_0010);

    for (int i = 0; i < N_RANDOM; i++) begin
      add_link(pick_length(), pick_angle(), pick_length(), pick_angle());
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (link_queue.size() > 0 || in_valid || frames_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (2 * LATENCY) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dhlg_pkg.sv
hdl/dhlg_cordic_lane.sv
hdl/dhlg_merge.sv
hdl/dh_link_frame_generator.sv
dv/tb.sv
